>>> rtl/udxc_pkg.sv
package udxc_pkg;

  localparam int DIST_W = 48;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // configuration register indexes
  localparam logic [1:0] CFG_FRAME_LENGTH  = 2'd0;
  localparam logic [1:0] CFG_MAX_LAG       = 2'd1;
  localparam logic [1:0] CFG_ALPHA         = 2'd2;
  localparam logic [1:0] CFG_TEMPLATE_COLS = 2'd3;

  localparam logic [5:0]  FRAME_LENGTH_RST  = 6'd32;
  localparam logic [4:0]  MAX_LAG_RST       = 5'd31;
  localparam logic [15:0] ALPHA_RST         = 16'd4096;
  localparam logic [6:0]  TEMPLATE_COLS_RST = 7'd64;

  localparam logic KIND_TEMPLATE = 1'b0;
  localparam logic KIND_SIGNAL   = 1'b1;

  // controls broadcast to every correlation cell
  typedef struct packed {
    logic load;   // parallel load of the signal tap
    logic mul;    // multiply tap by template sample, shift taps
    logic acc;    // add registered product into accumulator
    logic clr;    // clear accumulator
    logic drain;  // shift accumulators toward cell 0
  } cell_ctl_t;

  function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                input logic [DIST_W-1:0] b);
    logic [DIST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
  endfunction

endpackage

>>> rtl/unanchored_dtw_xcorr_cost_unit.sv
// Subsequence DTW over a stored template with a cross-correlation cost.
// Template samples (kind 0) and signal samples are taken while the block is
// idle. A signal sample that completes a column makes the block busy, and
// the block then works through every template column in use in turn: the
// load and multiply-accumulate in a row of 2*MAX_FRAME-1 lag cells, a drain
// of that row past the peak search, a bit-serial divider (used only when the
// peak is positive) and the weighting and row update. After a column with
// last_column set, the results are emitted one by one, each held while
// out_stall is high. The cost row has valid bits, so there is no clearing
// pass after reset. Template entries hold nothing until written.
module unanchored_dtw_xcorr_cost_unit import udxc_pkg::*; #(
  parameter int MAX_FRAME        = 32,
  parameter int TEMPLATE_COLUMNS = 64,
  parameter int SAMPLE_BITS      = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [5:0]                    in_column,
  input  logic [4:0]                    in_position,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_first_column,
  input  logic                          in_last_column,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [5:0]                    out_template_index,
  output logic [DIST_W-1:0]             out_distance,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [15:0]                   cfg_data
);

  localparam int NCELL = 2*MAX_FRAME - 1;
  localparam int LINE  = 3*MAX_FRAME - 2;
  localparam int CW    = $clog2(NCELL);
  localparam int ACC_W = 2*SAMPLE_BITS + $clog2(MAX_FRAME);
  localparam int KW    = $clog2(MAX_FRAME + 1);
  localparam int MCW   = $clog2(MAX_FRAME + 2);
  localparam int TA_W  = $clog2(TEMPLATE_COLUMNS * MAX_FRAME);
  localparam int JW    = (TEMPLATE_COLUMNS > 1) ? $clog2(TEMPLATE_COLUMNS) : 1;
  localparam int NTW   = $clog2(TEMPLATE_COLUMNS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_MAC, S_DRAIN, S_PEAK, S_DIV, S_MUL1, S_MUL2,
    S_SUM, S_UPD, S_ERD, S_EWT, S_EOUT
  } state_t;

  state_t state_r;

  logic [5:0]  freg_r;
  logic [4:0]  lreg_r;
  logic [15:0] areg_r;
  logic [6:0]  treg_r;

  logic [KW-1:0]  k_w;
  logic [KW-1:0]  lc_w;
  logic [NTW-1:0] nt_w;
  logic [CW-1:0]  lo_w, hi_w;

  always_comb begin
    if (freg_r == '0) begin
      k_w = KW'(1);
    end else if (int'(freg_r) > MAX_FRAME) begin
      k_w = KW'(MAX_FRAME);
    end else begin
      k_w = KW'(freg_r);
    end
    if (int'(lreg_r) > int'(k_w) - 1) begin
      lc_w = k_w - 1'b1;
    end else begin
      lc_w = KW'(lreg_r);
    end
    if (treg_r == '0) begin
      nt_w = NTW'(1);
    end else if (int'(treg_r) > TEMPLATE_COLUMNS) begin
      nt_w = NTW'(TEMPLATE_COLUMNS);
    end else begin
      nt_w = NTW'(treg_r);
    end
    lo_w = CW'(MAX_FRAME - 1) - CW'(lc_w);
    hi_w = CW'(MAX_FRAME - 1) + CW'(lc_w);
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freg_r <= FRAME_LENGTH_RST;
      lreg_r <= MAX_LAG_RST;
      areg_r <= ALPHA_RST;
      treg_r <= TEMPLATE_COLS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FRAME_LENGTH:  freg_r <= cfg_data[5:0];
        CFG_MAX_LAG:       lreg_r <= cfg_data[4:0];
        CFG_ALPHA:         areg_r <= cfg_data;
        CFG_TEMPLATE_COLS: treg_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  logic in_xfer;
  logic col_done;
  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign col_done = in_xfer && (in_kind == KIND_SIGNAL) &&
                    (int'(in_position) == int'(k_w) - 1);

  // signal column
  logic signed [SAMPLE_BITS-1:0] sig_r [MAX_FRAME];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_FRAME; i++) begin
        sig_r[i] <= '0;
      end
    end else if (in_xfer && in_kind == KIND_SIGNAL) begin
      for (int i = 0; i < MAX_FRAME; i++) begin
        if (int'(in_position) == i) begin
          sig_r[i] <= in_sample;
        end
      end
    end
  end

  // template store
  logic signed [SAMPLE_BITS-1:0] tmem [TEMPLATE_COLUMNS*MAX_FRAME];
  logic signed [SAMPLE_BITS-1:0] tmem_rd_r;
  logic                          tmem_we;
  logic [TA_W-1:0]               tmem_waddr;
  logic [TA_W-1:0]               tmem_raddr;
  logic [JW-1:0]                 j_r;
  logic [MCW-1:0]                mac_cnt_r;

  assign tmem_we    = in_xfer && (in_kind == KIND_TEMPLATE) &&
                      (int'(in_column) < TEMPLATE_COLUMNS) &&
                      (int'(in_position) < MAX_FRAME);
  assign tmem_waddr = TA_W'(TA_W'(in_column) * TA_W'(MAX_FRAME) + TA_W'(in_position));
  assign tmem_raddr = TA_W'(TA_W'(j_r) * TA_W'(MAX_FRAME) + TA_W'(mac_cnt_r));

  always_ff @(posedge clk) begin
    if (tmem_we) begin
      tmem[tmem_waddr] <= in_sample;
    end
    tmem_rd_r <= tmem[tmem_raddr];
  end

  // cost row with valid bits
  logic [DIST_W-1:0] row_mem [TEMPLATE_COLUMNS];
  logic [DIST_W-1:0] rd_data_r;
  logic              rdv_r;
  logic [TEMPLATE_COLUMNS-1:0] rowv_r;
  logic [JW-1:0]     row_addr_r;
  logic              row_we;
  logic [DIST_W-1:0] best;
  logic [DIST_W-1:0] old_j;

  assign row_we = (state_r == S_UPD);
  assign old_j  = rdv_r ? rd_data_r : '0;

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_addr_r] <= best;
    end
    rd_data_r <= row_mem[row_addr_r];
    rdv_r     <= rowv_r[row_addr_r];
  end

  // lag cells
  cell_ctl_t ctl;
  logic v1_r, v2_r;
  logic signed [SAMPLE_BITS-1:0] lv   [LINE];
  logic signed [SAMPLE_BITS-1:0] taps [NCELL];
  logic signed [ACC_W-1:0]       accs [NCELL];
  logic signed [SAMPLE_BITS-1:0] tail_r [MAX_FRAME-1];

  always_comb begin
    ctl.load  = (state_r == S_LOAD);
    ctl.clr   = (state_r == S_LOAD);
    ctl.mul   = v1_r;
    ctl.acc   = v2_r;
    ctl.drain = (state_r == S_DRAIN);
  end

  for (genvar i = 0; i < LINE; i++) begin : g_lv
    localparam int IDX = i - (MAX_FRAME - 1);
    if (IDX < 0 || IDX >= MAX_FRAME) begin : g_zero
      assign lv[i] = '0;
    end else begin : g_sig
      assign lv[i] = (KW'(IDX) < k_w) ? sig_r[IDX] : '0;
    end
  end

  for (genvar c = 0; c < NCELL; c++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] nb_tap;
    logic signed [ACC_W-1:0]       nb_acc;
    if (c == NCELL - 1) begin : g_end
      assign nb_tap = tail_r[0];
      assign nb_acc = '0;
    end else begin : g_mid
      assign nb_tap = taps[c+1];
      assign nb_acc = accs[c+1];
    end
    udxc_cell #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .ACC_W      (ACC_W)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .load_val(lv[c]),
      .tap_in  (nb_tap),
      .tap_out (taps[c]),
      .tmpl    (tmem_rd_r),
      .acc_in  (nb_acc),
      .acc_out (accs[c])
    );
  end

  // zero-padded tail of the signal line beyond the last cell
  always_ff @(posedge clk) begin
    for (int t = 0; t < MAX_FRAME - 1; t++) begin
      if (ctl.load) begin
        tail_r[t] <= lv[NCELL + t];
      end else if (ctl.mul) begin
        tail_r[t] <= (t == MAX_FRAME - 2) ? '0 : tail_r[t+1];
      end
    end
  end

  // divider
  logic signed [ACC_W-1:0] peak_r;
  logic                    have_r;
  logic                    div_start;
  logic                    div_done;
  logic [DIST_W:0]         div_q;

  assign div_start = (state_r == S_PEAK) && (peak_r > 0);

  udxc_div #(
    .ACC_W(ACC_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .divisor (peak_r[ACC_W-2:0]),
    .done    (div_done),
    .quotient(div_q)
  );

  // datapath
  logic [CW-1:0]     m_r;
  logic [DIST_W-1:0] cost_r, w_r, diag_r, left_r, up_r, lf_r, dg_r;
  logic [39:0]       ph_r, pl_r;
  logic [63:0]       wsum;
  logic [51:0]       wsh;
  logic              fresh_r;
  logic              lastc_r;
  logic              in_win;
  logic              j_end;
  logic [5:0]        oidx_r;
  logic [DIST_W-1:0] odist_r;
  logic              olast_r;

  always_comb begin
    wsum   = {ph_r, 24'd0} + {24'd0, pl_r};
    wsh    = wsum[63:12];
    in_win = (m_r >= lo_w) && (m_r <= hi_w);
    j_end  = (NTW'(j_r) == nt_w - 1'b1);
    best   = up_r;
    if (lf_r < best) begin
      best = lf_r;
    end
    if (dg_r < best) begin
      best = dg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      rowv_r     <= '0;
      fresh_r    <= 1'b1;
      j_r        <= '0;
      row_addr_r <= '0;
      mac_cnt_r  <= '0;
      m_r        <= '0;
      have_r     <= 1'b0;
      lastc_r    <= 1'b0;
      olast_r    <= 1'b0;
    end else begin
      v1_r <= (state_r == S_MAC) && (int'(mac_cnt_r) < int'(k_w));
      v2_r <= v1_r;
      unique case (state_r)
        S_IDLE: begin
          if (col_done) begin
            j_r        <= '0;
            row_addr_r <= '0;
            lastc_r    <= in_last_column;
            left_r     <= DIST_MAX;
            diag_r     <= (in_first_column || fresh_r) ? '0 : DIST_MAX;
            if (in_first_column) begin
              rowv_r  <= '0;
              fresh_r <= 1'b1;
            end
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          mac_cnt_r <= '0;
          have_r    <= 1'b0;
          state_r   <= S_MAC;
        end
        S_MAC: begin
          mac_cnt_r <= mac_cnt_r + 1'b1;
          if (int'(mac_cnt_r) == int'(k_w) + 1) begin
            m_r     <= '0;
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // cell 0 shows the accumulator that started in cell m
          if (in_win && (!have_r || accs[0] > peak_r)) begin
            peak_r <= accs[0];
            have_r <= 1'b1;
          end
          m_r <= m_r + 1'b1;
          if (m_r == CW'(NCELL - 1)) begin
            state_r <= S_PEAK;
          end
        end
        S_PEAK: begin
          if (peak_r > 0) begin
            state_r <= S_DIV;
          end else begin
            cost_r  <= DIST_MAX;
            state_r <= S_MUL1;
          end
        end
        S_DIV: begin
          if (div_done) begin
            cost_r  <= div_q[DIST_W] ? DIST_MAX : div_q[DIST_W-1:0];
            state_r <= S_MUL1;
          end
        end
        S_MUL1: begin
          ph_r    <= cost_r[47:24] * areg_r;
          pl_r    <= cost_r[23:0] * areg_r;
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          w_r     <= (wsh[51:48] != '0) ? DIST_MAX : wsh[47:0];
          state_r <= S_SUM;
        end
        S_SUM: begin
          up_r    <= sat_add(old_j, w_r);
          lf_r    <= sat_add(left_r, w_r);
          dg_r    <= sat_add(diag_r, cost_r);
          state_r <= S_UPD;
        end
        S_UPD: begin
          rowv_r[row_addr_r] <= 1'b1;
          diag_r <= old_j;
          left_r <= best;
          if (j_end) begin
            fresh_r <= 1'b0;
            j_r        <= '0;
            row_addr_r <= '0;
            state_r    <= lastc_r ? S_ERD : S_IDLE;
          end else begin
            j_r        <= j_r + 1'b1;
            row_addr_r <= j_r + 1'b1;
            state_r    <= S_LOAD;
          end
        end
        S_ERD: begin
          state_r <= S_EWT;
        end
        S_EWT: begin
          odist_r <= old_j;
          oidx_r  <= 6'(j_r);
          olast_r <= j_end;
          state_r <= S_EOUT;
        end
        S_EOUT: begin
          if (!out_stall) begin
            if (olast_r) begin
              state_r <= S_IDLE;
            end else begin
              j_r        <= j_r + 1'b1;
              row_addr_r <= j_r + 1'b1;
              state_r    <= S_ERD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = (state_r == S_EOUT);
  assign out_template_index = oidx_r;
  assign out_distance       = odist_r;
  assign out_last           = olast_r;

  a_no_input_while_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_template_index == 6'(nt_w - 1'b1)))
    else $error("last flag not on final template column");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside divide phase");

  a_div_start_peak: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> (state_r == S_DIV))
    else $error("divider started without entering divide phase");

endmodule

>>> rtl/udxc_cell.sv
module udxc_cell import udxc_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int ACC_W       = 37
) (
  input  logic                          clk,
  input  cell_ctl_t                     ctl,
  input  logic signed [SAMPLE_BITS-1:0] load_val,
  input  logic signed [SAMPLE_BITS-1:0] tap_in,
  output logic signed [SAMPLE_BITS-1:0] tap_out,
  input  logic signed [SAMPLE_BITS-1:0] tmpl,
  input  logic signed [ACC_W-1:0]       acc_in,
  output logic signed [ACC_W-1:0]       acc_out
);

  logic signed [SAMPLE_BITS-1:0]   tap_r;
  logic signed [2*SAMPLE_BITS-1:0] prod_r;
  logic signed [ACC_W-1:0]         acc_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      tap_r <= load_val;
    end else if (ctl.mul) begin
      tap_r <= tap_in;
    end
    if (ctl.mul) begin
      prod_r <= tap_r * tmpl;
    end
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (ctl.acc) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end else if (ctl.drain) begin
      acc_r <= acc_in;
    end
  end

  assign tap_out = tap_r;
  assign acc_out = acc_r;

endmodule

>>> rtl/udxc_div.sv
module udxc_div import udxc_pkg::*; #(
  parameter int ACC_W = 37
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [ACC_W-2:0]   divisor,
  output logic               done,
  output logic [DIST_W:0]    quotient
);

  // restoring division of 2^DIST_W by a positive divisor, one bit a cycle
  localparam int CNT_W = $clog2(DIST_W + 1);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [ACC_W-1:0]   rem_r;
  logic [DIST_W:0]    q_r;
  logic [ACC_W-2:0]   div_r;
  logic [ACC_W-1:0]   rem_sh;
  logic               fits;

  always_comb begin
    rem_sh = {rem_r[ACC_W-2:0], (cnt_r == CNT_W'(DIST_W))};
    fits   = rem_sh >= {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= CNT_W'(DIST_W);
      rem_r <= '0;
      q_r   <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      rem_r <= fits ? rem_sh - {1'b0, div_r} : rem_sh;
      q_r   <= {q_r[DIST_W-1:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

>>> test/tb_unanchored_dtw_xcorr_cost_unit.sv
`timescale 1ns / 100ps

module tb_unanchored_dtw_xcorr_cost_unit;
  import udxc_pkg::*;

  localparam int  MAXF   = 32;
  localparam int  NCOLS  = 64;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic        kind;
    logic [5:0]  column;
    logic [4:0]  position;
    logic [15:0] sample;
    logic        first;
    logic        last;
    bit          all_max;  // expected row is all ones, typed in
  } stim_row_t;

  typedef struct {
    logic [5:0]        index;
    logic [DIST_W-1:0] distance;
    logic              last;
  } dist_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_kind = 1'b0, in_first_column = 1'b0, in_last_column = 1'b0;
  logic [5:0] in_column = '0;
  logic [4:0] in_position = '0;
  logic signed [15:0] in_sample = '0;
  logic in_stall, out_valid, out_last, cfg_ready;
  logic out_stall = 1'b0;
  logic [5:0] out_template_index;
  logic [DIST_W-1:0] out_distance;
  logic cfg_valid = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  unanchored_dtw_xcorr_cost_unit dut (.*);

  always #6 clk = ~clk;

  // predictor state
  logic signed [15:0] tmpl_mem [NCOLS*MAXF];
  logic signed [15:0] sig_col [MAXF];
  logic [DIST_W-1:0]  cost_row [NCOLS];
  bit                 row_start;
  logic [5:0]  frame_len_reg;
  logic [4:0]  lag_reg;
  logic [15:0] alpha_reg;
  logic [6:0]  ncols_reg;

  dist_t  pending_dist[$];
  int     mismatches = 0;
  longint cycles = 0;
  bit     steady = 1'b0;

  function automatic int used_k();
    if (frame_len_reg == 0) return 1;
    if (frame_len_reg > MAXF) return MAXF;
    return int'(frame_len_reg);
  endfunction

  function automatic int used_nt();
    if (ncols_reg == 0) return 1;
    if (ncols_reg > NCOLS) return NCOLS;
    return int'(ncols_reg);
  endfunction

  function automatic logic [DIST_W-1:0] xcorr_cost(int col, int k);
    int lmax;
    longint acc, peak;
    bit have;
    logic [63:0] c;
    lmax = int'(lag_reg);
    have = 1'b0;
    peak = 0;
    if (lmax > k - 1) lmax = k - 1;
    for (int lag = -lmax; lag <= lmax; lag++) begin
      acc = 0;
      for (int p = 0; p < k; p++)
        if (p + lag >= 0 && p + lag < k)
          acc += longint'(sig_col[p+lag]) * longint'(tmpl_mem[col*MAXF+p]);
      if (!have || acc > peak) begin
        peak = acc;
        have = 1'b1;
      end
    end
    if (peak <= 0) return DIST_MAX;
    c = (64'd1 << 48) / 64'(peak);
    return (c > 64'(DIST_MAX)) ? DIST_MAX : c[DIST_W-1:0];
  endfunction

  // advance the DTW row for one accepted item; queue any distances it emits
  function automatic void predict_row(stim_row_t r);
    int k, nt;
    logic [DIST_W-1:0] c, w, left, diag, best, up, lf, dg;
    logic [63:0] wide;
    dist_t d;
    if (r.kind == KIND_TEMPLATE) begin
      tmpl_mem[r.column*MAXF + r.position] = r.sample;
      return;
    end
    sig_col[r.position] = r.sample;
    k = used_k();
    if (r.position != k - 1) return;
    if (r.first) begin
      foreach (cost_row[j]) cost_row[j] = '0;
      row_start = 1'b1;
    end
    nt = used_nt();
    diag = row_start ? '0 : DIST_MAX;
    left = DIST_MAX;
    for (int j = 0; j < nt; j++) begin
      c = xcorr_cost(j, k);
      wide = (64'(c) * 64'(alpha_reg)) >> 12;
      w = (wide > 64'(DIST_MAX)) ? DIST_MAX : wide[DIST_W-1:0];
      up = sat_add(cost_row[j], w);
      lf = sat_add(left, w);
      dg = sat_add(diag, c);
      best = up;
      if (lf < best) best = lf;
      if (dg < best) best = dg;
      diag = cost_row[j];
      cost_row[j] = best;
      left = best;
    end
    row_start = 1'b0;
    if (!r.last) return;
    for (int j = 0; j < nt; j++) begin
      d.index = j[5:0];
      d.distance = r.all_max ? DIST_MAX : cost_row[j];
      d.last = (j == nt - 1);
      pending_dist.push_back(d);
    end
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) out_stall <= !steady && ($urandom_range(99) < 31);

  always @(posedge clk) begin
    dist_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_dist.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected distance idx=%0d dist=%h", out_template_index, out_distance);
      end else begin
        e = pending_dist.pop_front();
        if (e.index !== out_template_index || e.distance !== out_distance ||
            e.last !== out_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp idx=%0d dist=%h last=%b, got idx=%0d dist=%h last=%b",
                     e.index, e.distance, e.last,
                     out_template_index, out_distance, out_last);
        end
      end
    end
  end

  task automatic send(stim_row_t r);
    while (!steady && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= r.kind;
    in_column       <= r.column;
    in_position     <= r.position;
    in_sample       <= r.sample;
    in_first_column <= r.first;
    in_last_column  <= r.last;
    do @(posedge clk); while (in_stall);
    predict_row(r);
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // let every expected distance arrive, then cover a column still in flight
  task automatic drain();
    while (pending_dist.size() != 0) @(posedge clk);
    repeat (used_nt() * (used_k() + 4*MAXF + 60) + 64) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FRAME_LENGTH:  frame_len_reg = val[5:0];
      CFG_MAX_LAG:       lag_reg       = val[4:0];
      CFG_ALPHA:         alpha_reg     = val;
      CFG_TEMPLATE_COLS: ncols_reg     = val[6:0];
      default: ;
    endcase
  endtask

  task automatic setup(logic [15:0] k, logic [15:0] lag, logic [15:0] a, logic [15:0] n);
    write_reg(CFG_FRAME_LENGTH, k);
    write_reg(CFG_MAX_LAG, lag);
    write_reg(CFG_ALPHA, a);
    write_reg(CFG_TEMPLATE_COLS, n);
    cfg_valid <= 1'b0;
  endtask

  // every template entry the current setting reads gets written first
  task automatic fill_template();
    stim_row_t r;
    r = '{KIND_TEMPLATE, 0, 0, 0, 0, 0, 0};
    for (int j = 0; j < used_nt(); j++)
      for (int p = 0; p < used_k(); p++) begin
        r.column = 6'(j);
        r.position = 5'(p);
        r.sample = 16'($urandom);
        r.first = 1'($urandom);
        r.last = 1'($urandom);
        send(r);
      end
  endtask

  task automatic random_items(int count, bit hold_mid);
    stim_row_t r;
    int sent, sel;
    bit new_row;
    sent = 0;
    new_row = 1'b1;
    while (sent < count) begin
      if (hold_mid && sent >= count / 2) begin
        hold_mid = 1'b0;
        in_valid <= 1'b0;
        while (pending_dist.size() != 0) @(posedge clk);
      end
      sel = $urandom_range(99);
      r = '{KIND_SIGNAL, 0, 0, 0, 0, 0, 0};
      if (sel < 75) begin
        for (int p = 0; p < used_k(); p++) begin
          r.column = 6'($urandom);
          r.position = 5'(p);
          r.sample = 16'($urandom);
          r.first = new_row || ($urandom_range(15) == 0);
          r.last = ($urandom_range(2) == 0);
          send(r);
          sent++;
        end
        new_row = r.last;
      end else if (sel < 90) begin
        r.kind = KIND_TEMPLATE;
        r.column = 6'($urandom);
        r.position = 5'($urandom);
        r.sample = 16'($urandom);
        send(r);
        sent++;
      end else begin
        r.column = 6'($urandom);
        r.position = 5'($urandom);
        r.sample = 16'($urandom);
        r.first = 1'($urandom);
        r.last = 1'($urandom);
        send(r);
        sent++;
      end
    end
    idle_input();
  endtask

  stim_row_t dir_rows [16];

  initial begin
    frame_len_reg = FRAME_LENGTH_RST;
    lag_reg       = MAX_LAG_RST;
    alpha_reg     = ALPHA_RST;
    ncols_reg     = TEMPLATE_COLS_RST;
    foreach (tmpl_mem[i]) tmpl_mem[i] = '0;
    foreach (sig_col[i]) sig_col[i] = '0;
    foreach (cost_row[i]) cost_row[i] = '0;
    row_start = 1'b1;

    dir_rows = '{
      '{KIND_TEMPLATE, 6'd0,  5'd0,  16'h7fff, 1'b0, 1'b0, 1'b0},
      '{KIND_TEMPLATE, 6'd0,  5'd1,  16'h8000, 1'b0, 1'b0, 1'b0},
      '{KIND_TEMPLATE, 6'd1,  5'd0,  16'hffff, 1'b1, 1'b1, 1'b0},
      '{KIND_TEMPLATE, 6'd1,  5'd1,  16'h0001, 1'b0, 1'b0, 1'b0},
      // zero column: peak not positive, whole fresh row saturates
      '{KIND_SIGNAL,   6'd0,  5'd0,  16'h0000, 1'b0, 1'b0, 1'b0},
      '{KIND_SIGNAL,   6'd0,  5'd1,  16'h0000, 1'b1, 1'b1, 1'b1},
      '{KIND_SIGNAL,   6'd0,  5'd0,  16'h7fff, 1'b0, 1'b0, 1'b0},
      '{KIND_SIGNAL,   6'd63, 5'd1,  16'h7fff, 1'b1, 1'b0, 1'b0},
      // beyond k: stored, unused
      '{KIND_SIGNAL,   6'd0,  5'd31, 16'h8000, 1'b1, 1'b1, 1'b0},
      // flags ignored off the completing sample
      '{KIND_SIGNAL,   6'd0,  5'd0,  16'h8000, 1'b1, 1'b1, 1'b0},
      '{KIND_SIGNAL,   6'd0,  5'd1,  16'h8000, 1'b0, 1'b1, 1'b0},
      '{KIND_SIGNAL,   6'd0,  5'd1,  16'h3039, 1'b0, 1'b1, 1'b0},
      '{KIND_TEMPLATE, 6'd63, 5'd31, 16'h8000, 1'b0, 1'b0, 1'b0},
      '{KIND_TEMPLATE, 6'd0,  5'd0,  16'h0001, 1'b0, 1'b0, 1'b0},
      '{KIND_SIGNAL,   6'd0,  5'd0,  16'h0001, 1'b0, 1'b0, 1'b0},
      '{KIND_SIGNAL,   6'd0,  5'd1,  16'hffff, 1'b1, 1'b1, 1'b0}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    setup(16'd2, 16'd1, 16'd4096, 16'd2);
    foreach (dir_rows[i]) send(dir_rows[i]);
    idle_input();
    drain();

    // odd values: k 0 counts as 1, lag clamps to 0, nt 127 counts as 64
    setup(16'd0, 16'd31, 16'd0, 16'd127);
    fill_template();
    random_items(12, 1'b0);
    drain();

    // k 63 counts as 32, nt 0 counts as 1; no idling here
    setup(16'd63, 16'd0, 16'd65535, 16'd0);
    steady = 1'b1;
    fill_template();
    random_items(100, 1'b0);
    steady = 1'b0;
    drain();

    setup(16'd5, 16'd4, 16'd2048, 16'd8);
    fill_template();
    random_items(70, 1'b1);
    drain();

    setup(16'd3, 16'd2, 16'd12288, 16'd3);
    fill_template();
    random_items(60, 1'b0);

    while (pending_dist.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_dist.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
